// ----- rtl/core/ccs_pkg.sv -----
// Shared types and constants for the circular successor search block.
// Used by ccs_front, ccs_back and circular_successor_search_top; no dependencies.
`timescale 1ns / 1ps

package ccs_pkg;

  // Key store geometry
  localparam int DEPTH  = 512;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Word fields
  localparam int KEY_W  = 16;
  localparam int POS_W  = 9;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TARGET = 2'd2,
    CMD_LOWEST = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_TARGET,
    OP_LOWEST
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DONE
  } back_state_e;

  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

// ----- rtl/core/ccs_front.sv -----
// Front end: accepts input words, decodes the command and queues them.
// Depends on ccs_pkg.
`timescale 1ns / 1ps

module ccs_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ccs_pkg::CMD_W-1:0]  in_cmd_i,
  input  logic [ccs_pkg::KEY_W-1:0]  in_key_i,
  output ccs_pkg::q_head_t           head_o,
  input  logic                       pop_i
);

  ccs_pkg::item_t            entries_q [ccs_pkg::QDEPTH];
  logic [ccs_pkg::QA_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [ccs_pkg::QA_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [ccs_pkg::QC_W-1:0]  fill_q, fill_d;
  ccs_pkg::item_t            dec_item;
  logic                      push, pop;

  // decode the command into an operation
  always_comb begin
    dec_item.key = in_key_i;
    case (in_cmd_i)
      ccs_pkg::CMD_CLEAR:  dec_item.op = ccs_pkg::OP_CLEAR;
      ccs_pkg::CMD_APPEND: dec_item.op = ccs_pkg::OP_APPEND;
      ccs_pkg::CMD_TARGET: dec_item.op = ccs_pkg::OP_TARGET;
      ccs_pkg::CMD_LOWEST: dec_item.op = ccs_pkg::OP_LOWEST;
      default:             dec_item.op = ccs_pkg::OP_LOWEST;
    endcase
  end

  assign in_ready_o = (fill_q != ccs_pkg::QC_W'(ccs_pkg::QDEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (fill_q != '0);

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + ccs_pkg::QA_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + ccs_pkg::QA_W'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + ccs_pkg::QC_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - ccs_pkg::QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= dec_item;
    end
  end

  assign head_o.valid = (fill_q != '0);
  assign head_o.item  = entries_q[rd_ptr_q];

endmodule

// ----- rtl/core/ccs_back.sv -----
// Back end: key store, entry count, scan engine and output register.
// Depends on ccs_pkg; fed by the ccs_front queue.
`timescale 1ns / 1ps

module ccs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ccs_pkg::q_head_t            head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ccs_pkg::POS_W-1:0]   out_pos_o,
  output logic                        out_wrap_o,
  output logic [ccs_pkg::STAT_W-1:0]  out_status_o
);

  logic [ccs_pkg::KEY_W-1:0] mem [ccs_pkg::DEPTH];

  ccs_pkg::back_state_e        state_q, state_d;
  ccs_pkg::item_t              cur_q, cur_d;
  logic [ccs_pkg::CNT_W-1:0]   count_q, count_d;
  logic [ccs_pkg::CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic                        rd_vld_q, rd_vld_d;
  logic [ccs_pkg::KEY_W-1:0]   rdata_q;
  logic [ccs_pkg::ADDR_W-1:0]  rpos_q;
  logic                        found_q, found_d;
  logic [ccs_pkg::KEY_W-1:0]   gt_key_q, gt_key_d;
  logic [ccs_pkg::ADDR_W-1:0]  gt_pos_q, gt_pos_d;
  logic [ccs_pkg::KEY_W-1:0]   min_key_q, min_key_d;
  logic [ccs_pkg::ADDR_W-1:0]  min_pos_q, min_pos_d;
  logic                        out_valid_q, out_valid_d;
  logic [ccs_pkg::POS_W-1:0]   out_pos_q;
  logic                        out_wrap_q;
  ccs_pkg::stat_e              out_status_q;

  logic                        out_free, out_load, mem_we, rd_en, full;
  logic [ccs_pkg::ADDR_W-1:0]  res_pos;
  logic                        res_wrap;
  ccs_pkg::stat_e              res_status;

  assign out_free = !out_valid_q || out_ready_i;
  assign full     = (count_q == ccs_pkg::CNT_W'(ccs_pkg::DEPTH));

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    rd_vld_d   = 1'b0;
    found_d    = found_q;
    gt_key_d   = gt_key_q;
    gt_pos_d   = gt_pos_q;
    min_key_d  = min_key_q;
    min_pos_d  = min_pos_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    res_pos    = '0;
    res_wrap   = 1'b0;
    res_status = ccs_pkg::ST_OK;

    // fold one read word into the running successor and minimum
    if (rd_vld_q) begin
      if ((rdata_q > cur_q.key) && (!found_q || (rdata_q < gt_key_q))) begin
        found_d  = 1'b1;
        gt_key_d = rdata_q;
        gt_pos_d = rpos_q;
      end
      if ((rpos_q == '0) || (rdata_q < min_key_q)) begin
        min_key_d = rdata_q;
        min_pos_d = rpos_q;
      end
    end

    case (state_q)
      ccs_pkg::B_IDLE: begin
        if (head_i.valid && out_free) begin
          pop_o = 1'b1;
          case (head_i.item.op)
            ccs_pkg::OP_CLEAR: begin
              count_d  = '0;
              out_load = 1'b1;
            end
            ccs_pkg::OP_APPEND: begin
              out_load = 1'b1;
              if (full) begin
                res_status = ccs_pkg::ST_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + ccs_pkg::CNT_W'(1);
              end
            end
            default: begin
              if (count_q == '0) begin
                res_status = ccs_pkg::ST_EMPTY;
                out_load   = 1'b1;
              end else begin
                cur_d    = head_i.item;
                rd_idx_d = '0;
                found_d  = 1'b0;
                state_d  = ccs_pkg::B_SCAN;
              end
            end
          endcase
        end
      end
      ccs_pkg::B_SCAN: begin
        if (rd_idx_q != count_q) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = rd_idx_q + ccs_pkg::CNT_W'(1);
        end else if (!rd_vld_q) begin
          state_d = ccs_pkg::B_DONE;
        end
      end
      ccs_pkg::B_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          if ((cur_q.op == ccs_pkg::OP_TARGET) && found_q) begin
            res_pos = gt_pos_q;
          end else begin
            res_pos = min_pos_q;
          end
          res_wrap = (cur_q.op == ccs_pkg::OP_TARGET) && !found_q;
          state_d  = ccs_pkg::B_IDLE;
        end
      end
      default: state_d = ccs_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ccs_pkg::B_IDLE;
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    rd_idx_q  <= rd_idx_d;
    found_q   <= found_d;
    gt_key_q  <= gt_key_d;
    gt_pos_q  <= gt_pos_d;
    min_key_q <= min_key_d;
    min_pos_q <= min_pos_d;
    if (out_load) begin
      out_pos_q    <= ccs_pkg::POS_W'(res_pos);
      out_wrap_q   <= res_wrap;
      out_status_q <= res_status;
    end
  end

  // key store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[ccs_pkg::ADDR_W-1:0]] <= head_i.item.key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_idx_q[ccs_pkg::ADDR_W-1:0]];
      rpos_q  <= rd_idx_q[ccs_pkg::ADDR_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_pos_o    = out_pos_q;
  assign out_wrap_o   = out_wrap_q;
  assign out_status_o = out_status_q;

`ifndef SYNTH
  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (count_q < ccs_pkg::CNT_W'(ccs_pkg::DEPTH)))
    else $error("key store written past its depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ccs_pkg::B_SCAN) |-> ((rd_idx_q <= count_q) && (count_q != '0)))
    else $error("scan index beyond entry count");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten while held");

  a_read_only_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (state_q == ccs_pkg::B_SCAN))
    else $error("key store read outside scan");
`endif

endmodule

// ----- rtl/core/circular_successor_search_top.sv -----
// A clear/append word is popped from the queue and loaded into the output
// register; a query on N > 0 stored keys scans them all, then loads its result.
// The scan reads one entry per cycle through the key store's single read port.
// Clear/append sustain one word per cycle while no scan runs and m_axis is ready.
// Reset: asynchronous, active low; clears the queue, entry count and output
// valid. The key store is not cleared, so no clearing pass is needed.
`timescale 1ns / 1ps

module circular_successor_search_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] key
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] cmd
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [8:0] position, [9] wrapped, [15:10] zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  ccs_pkg::q_head_t               head;
  logic                           pop;
  logic [ccs_pkg::POS_W-1:0]      res_pos;
  logic                           res_wrap;
  logic [ccs_pkg::STAT_W-1:0]     res_status;

  // Front end: take words, decode cmd, buffer in a two-word queue so the
  // input can still take words while the back end is busy with a scan.
  ccs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_cmd_i   (s_axis_tuser_i),
    .in_key_i   (s_axis_tdata_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // Back end: owns the key store and count, runs the linear scan and
  // holds the result in an output register until it is taken.
  ccs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_pos_o    (res_pos),
    .out_wrap_o   (res_wrap),
    .out_status_o (res_status)
  );

  // pack result word; upper bits padded with zeros
  assign m_axis_tdata_o = {6'b0, res_wrap, res_pos};
  assign m_axis_tuser_o = res_status;

endmodule
